// ===== rtl/thrust_to_pwm_duty_unit_assert.svh =====
// assertion macros shared by the thrust to pwm duty design
`ifndef THRUST_TO_PWM_DUTY_UNIT_ASSERT_SVH
`define THRUST_TO_PWM_DUTY_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TPD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpd assertion failed");

// next-cycle implication
`define TPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpd assertion failed");

`endif

// ===== rtl/tpd_pkg.sv =====
// types and constants of the thrust to pwm duty design
package tpd_pkg;

  typedef enum logic [1:0] {
    KIND_ABS  = 2'd0,
    KIND_REL  = 2'd1,
    KIND_STOP = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_CURVE_A       = 3'd0,
    REG_CURVE_B       = 3'd1,
    REG_CURVE_C       = 3'd2,
    REG_FORCE_FLOOR   = 3'd3,
    REG_FORCE_CEILING = 3'd4,
    REG_TRIM_FORCE    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] curve_a;
    logic signed [31:0] curve_b;
    logic signed [31:0] curve_c;
    logic signed [31:0] force_floor;
    logic signed [31:0] force_ceiling;
    logic signed [31:0] trim_force;
  } cfg_t;

  typedef struct packed {
    logic stop;
    logic cl;
    logic ch;
    logic err;
  } item_flags_t;

  typedef struct packed {
    item_flags_t flags;
    logic        qneg;
  } div_side_t;

  localparam int DISC_W = 67;   // discriminant width
  localparam int ROOT_W = 35;   // square root width
  localparam int MAG_W  = 53;   // dividend magnitude width
  localparam int T_W    = 54;   // signed numerator width

  localparam logic signed [T_W-1:0] IDLE_MUL  = 54'sd1000000;
  localparam logic signed [T_W-1:0] HALF_STEP = 54'sd5000;
  localparam int IDLE_NS = 1000000;

endpackage

// ===== rtl/tpd_front.sv =====
// request setup, clamp, coefficient products and discriminant
module tpd_front import tpd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  cfg_t                cfg,
  input  logic                in_ok,
  input  logic [1:0]          kind,
  input  logic signed [31:0]  force_value,
  output logic                d_valid,
  output logic [DISC_W-1:0]   d_disc,
  output item_flags_t         d_flags
);

  // stage 1: request with trim
  logic               v1;
  logic               stop1;
  logic signed [32:0] f1;
  // stage 2: clamp
  logic               v2;
  logic               stop2, cl2, ch2;
  logic signed [31:0] f2;
  // stage 3: products
  logic               v3;
  logic               stop3, cl3, ch3;
  logic signed [64:0] p3;
  logic [63:0]        b2_3;

  logic signed [32:0] lo_b, hi_b;
  logic signed [32:0] diff;
  logic signed [63:0] bsq;
  logic signed [67:0] disc_full;
  logic               err_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      d_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_ok;
      v2 <= v1;
      v3 <= v2;
      d_valid <= v3;
    end
  end

  assign lo_b = {cfg.force_floor[31], cfg.force_floor};
  assign hi_b = {cfg.force_ceiling[31], cfg.force_ceiling};
  assign diff = {cfg.curve_c[31], cfg.curve_c} - {f2[31], f2};
  assign bsq  = cfg.curve_b * cfg.curve_b;

  // a zero or a discriminant below zero
  assign err_now = (cfg.curve_a == 32'sd0) ||
                   ((p3 > 65'sd0) && (p3 > $signed({3'b000, b2_3[63:2]})));
  assign disc_full = $signed({4'b0000, b2_3}) - $signed({p3[64], p3, 2'b00});

  always_ff @(posedge clk) begin
    if (adv) begin
      stop1 <= (kind != KIND_ABS) && (kind != KIND_REL);
      if (kind == KIND_REL) begin
        f1 <= {force_value[31], force_value} + {cfg.trim_force[31], cfg.trim_force};
      end else begin
        f1 <= {force_value[31], force_value};
      end

      stop2 <= stop1;
      cl2   <= 1'b0;
      ch2   <= 1'b0;
      if (f1 < lo_b) begin
        f2  <= cfg.force_floor;
        cl2 <= 1'b1;
      end else if (f1 > hi_b) begin
        f2  <= cfg.force_ceiling;
        ch2 <= 1'b1;
      end else begin
        f2  <= f1[31:0];
      end

      stop3 <= stop2;
      cl3   <= cl2;
      ch3   <= ch2;
      p3    <= cfg.curve_a * diff;
      b2_3  <= bsq;

      d_disc  <= disc_full[DISC_W-1:0];
      d_flags <= '{stop: stop3, cl: cl3, ch: ch3, err: err_now};
    end
  end

endmodule

// ===== rtl/tpd_sqrt.sv =====
// pipelined integer square root, one root bit per stage
module tpd_sqrt import tpd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                d_valid,
  input  logic [DISC_W-1:0]   d_disc,
  input  item_flags_t         d_flags,
  output logic                s_valid,
  output logic [ROOT_W-1:0]   s_root,
  output item_flags_t         s_flags
);

  localparam int RW = 72;

  logic [RW-1:0]     rem_q   [1:ROOT_W];
  logic [ROOT_W-1:0] root_q  [1:ROOT_W];
  logic              valid_q [1:ROOT_W];
  item_flags_t       flags_q [1:ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    localparam int B = ROOT_W - 1 - i;
    logic [RW-1:0]     rem_in;
    logic [ROOT_W-1:0] root_in;
    logic              valid_in;
    item_flags_t       flags_in;
    logic [RW-1:0]     trial;
    logic              take;

    if (i == 0) begin : g_first
      assign rem_in   = RW'(d_disc);
      assign root_in  = '0;
      assign valid_in = d_valid;
      assign flags_in = d_flags;
    end else begin : g_rest
      assign rem_in   = rem_q[i];
      assign root_in  = root_q[i];
      assign valid_in = valid_q[i];
      assign flags_in = flags_q[i];
    end

    // remainder must cover 2*root*2^b + 2^2b
    assign trial = (RW'(root_in) << (B + 1)) | (RW'(1) << (2 * B));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[i+1] <= 1'b0;
      end else if (adv) begin
        valid_q[i+1] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[i+1]   <= take ? rem_in - trial : rem_in;
        root_q[i+1]  <= take ? (root_in | (ROOT_W'(1) << B)) : root_in;
        flags_q[i+1] <= flags_in;
      end
    end
  end

  assign s_valid = valid_q[ROOT_W];
  assign s_root  = root_q[ROOT_W];
  assign s_flags = flags_q[ROOT_W];

endmodule

// ===== rtl/tpd_scale.sv =====
// numerator of the pulse quotient: n = root - b, t = 1e6*a + 5000*n
module tpd_scale import tpd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  cfg_t                cfg,
  input  logic                s_valid,
  input  logic [ROOT_W-1:0]   s_root,
  input  item_flags_t         s_flags,
  output logic                m_valid,
  output logic [MAG_W-1:0]    m_mag,
  output div_side_t           m_side
);

  logic                v1, v2, v3;
  item_flags_t         fl1, fl2, fl3;
  logic signed [36:0]  n1;
  logic signed [T_W-1:0] m1a, m1b;
  logic signed [T_W-1:0] t3;
  logic signed [T_W-1:0] t_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      m_valid <= 1'b0;
    end else if (adv) begin
      v1 <= s_valid;
      v2 <= v1;
      v3 <= v2;
      m_valid <= v3;
    end
  end

  assign t_neg = -t3;

  always_ff @(posedge clk) begin
    if (adv) begin
      fl1 <= s_flags;
      n1  <= $signed({2'b00, s_root}) - $signed({{5{cfg.curve_b[31]}}, cfg.curve_b});

      fl2 <= fl1;
      m1a <= $signed({{22{cfg.curve_a[31]}}, cfg.curve_a}) * IDLE_MUL;
      m1b <= $signed({{17{n1[36]}}, n1}) * HALF_STEP;

      fl3 <= fl2;
      t3  <= m1a + m1b;

      // divide magnitudes, sign applied after
      m_mag  <= t3[T_W-1] ? t_neg[MAG_W-1:0] : t3[MAG_W-1:0];
      m_side <= '{flags: fl3, qneg: t3[T_W-1] ^ cfg.curve_a[31]};
    end
  end

endmodule

// ===== rtl/tpd_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module tpd_div import tpd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  cfg_t              cfg,
  input  logic              m_valid,
  input  logic [MAG_W-1:0]  m_mag,
  input  div_side_t         m_side,
  output logic              q_valid,
  output logic [MAG_W-1:0]  q_quot,
  output div_side_t         q_side
);

  logic [31:0] dmag;
  logic [31:0] a_neg;

  logic [31:0]      rem_q   [1:MAG_W];
  logic [MAG_W-1:0] dvd_q   [1:MAG_W];
  logic [MAG_W-1:0] quot_q  [1:MAG_W];
  logic             valid_q [1:MAG_W];
  div_side_t        side_q  [1:MAG_W];

  assign a_neg = -cfg.curve_a;
  assign dmag  = cfg.curve_a[31] ? a_neg : cfg.curve_a;

  for (genvar i = 0; i < MAG_W; i++) begin : g_step
    localparam int K = MAG_W - 1 - i;
    logic [31:0]      rem_in;
    logic [MAG_W-1:0] dvd_in;
    logic [MAG_W-1:0] quot_in;
    logic             valid_in;
    div_side_t        side_in;
    logic [32:0]      shifted;
    logic [32:0]      diff;
    logic             take;
    logic [MAG_W-1:0] quot_next;

    if (i == 0) begin : g_first
      assign rem_in   = '0;
      assign dvd_in   = m_mag;
      assign quot_in  = '0;
      assign valid_in = m_valid;
      assign side_in  = m_side;
    end else begin : g_rest
      assign rem_in   = rem_q[i];
      assign dvd_in   = dvd_q[i];
      assign quot_in  = quot_q[i];
      assign valid_in = valid_q[i];
      assign side_in  = side_q[i];
    end

    assign shifted = {rem_in, dvd_in[K]};
    assign diff    = shifted - {1'b0, dmag};
    assign take    = shifted >= {1'b0, dmag};

    always_comb begin
      quot_next    = quot_in;
      quot_next[K] = take;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[i+1] <= 1'b0;
      end else if (adv) begin
        valid_q[i+1] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[i+1]  <= take ? diff[31:0] : shifted[31:0];
        dvd_q[i+1]  <= dvd_in;
        quot_q[i+1] <= quot_next;
        side_q[i+1] <= side_in;
      end
    end
  end

  assign q_valid = valid_q[MAG_W];
  assign q_quot  = quot_q[MAG_W];
  assign q_side  = side_q[MAG_W];

endmodule

// ===== rtl/thrust_to_pwm_duty_unit.sv =====
// top level of the thrust request to esc pulse width pipeline
// pipeline from an accepted word to its result word on the output, registered in
//   4 setup stages, 35 root stages, 4 scale stages, 53 divide stages and 1 output stage
// throughput: one word per cycle; the whole pipe advances unless the output word is stalled
// reset: synchronous, active high; clears all valid bits and loads the register defaults
module thrust_to_pwm_duty_unit
  import tpd_pkg::*;
#(
  parameter int PERIOD_NS = 3333333
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic signed [31:0] force_value,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [21:0]        pulse_ns,
  output logic               clamped_low,
  output logic               clamped_high,
  output logic               math_error
);

  `include "thrust_to_pwm_duty_unit_assert.svh"

  // saturation bound and idle width, both as wide words
  localparam logic [31:0] PERIOD_W = 32'(PERIOD_NS);
  localparam logic [31:0] IDLE_W   = (IDLE_NS < PERIOD_NS) ? 32'(IDLE_NS) : 32'(PERIOD_NS);

  cfg_t cfg;

  // pipe moves whenever the output register is free or being drained
  logic adv;

  logic              d_valid;
  logic [DISC_W-1:0] d_disc;
  item_flags_t       d_flags;
  logic              s_valid;
  logic [ROOT_W-1:0] s_root;
  item_flags_t       s_flags;
  logic              m_valid;
  logic [MAG_W-1:0]  m_mag;
  div_side_t         m_side;
  logic              q_valid;
  logic [MAG_W-1:0]  q_quot;
  div_side_t         q_side;

  logic [31:0] pulse_wide;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.curve_a       <= 32'sd65536;
      cfg.curve_b       <= 32'sd0;
      cfg.curve_c       <= 32'sd0;
      cfg.force_floor   <= 32'sd0;
      cfg.force_ceiling <= 32'sd655360;
      cfg.trim_force    <= 32'sd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CURVE_A:       cfg.curve_a       <= cfg_data;
        REG_CURVE_B:       cfg.curve_b       <= cfg_data;
        REG_CURVE_C:       cfg.curve_c       <= cfg_data;
        REG_FORCE_FLOOR:   cfg.force_floor   <= cfg_data;
        REG_FORCE_CEILING: cfg.force_ceiling <= cfg_data;
        REG_TRIM_FORCE:    cfg.trim_force    <= cfg_data;
        default:           ;
      endcase
    end
  end

  // trim, clamp, products and discriminant
  tpd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .cfg         (cfg),
    .in_ok       (in_valid && !in_stall),
    .kind        (kind),
    .force_value (force_value),
    .d_valid     (d_valid),
    .d_disc      (d_disc),
    .d_flags     (d_flags)
  );

  // floor of the square root of the discriminant
  tpd_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .d_valid (d_valid),
    .d_disc  (d_disc),
    .d_flags (d_flags),
    .s_valid (s_valid),
    .s_root  (s_root),
    .s_flags (s_flags)
  );

  // numerator 1e6*a + 5000*(root - b), split into sign and magnitude
  tpd_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .cfg     (cfg),
    .s_valid (s_valid),
    .s_root  (s_root),
    .s_flags (s_flags),
    .m_valid (m_valid),
    .m_mag   (m_mag),
    .m_side  (m_side)
  );

  // magnitude quotient by |a|, truncated toward zero
  tpd_div u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .cfg     (cfg),
    .m_valid (m_valid),
    .m_mag   (m_mag),
    .m_side  (m_side),
    .q_valid (q_valid),
    .q_quot  (q_quot),
    .q_side  (q_side)
  );

  // stop and math errors give idle width, negative quotient floors at zero, larger quotient saturates at the period
  always_comb begin
    if (q_side.flags.stop || q_side.flags.err) begin
      pulse_wide = IDLE_W;
    end else if (q_side.qneg) begin
      pulse_wide = '0;
    end else if (q_quot > MAG_W'(PERIOD_W)) begin
      pulse_wide = PERIOD_W;
    end else begin
      pulse_wide = q_quot[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pulse_ns     <= pulse_wide[21:0];
      clamped_low  <= q_side.flags.cl && !q_side.flags.stop;
      clamped_high <= q_side.flags.ch && !q_side.flags.stop;
      math_error   <= q_side.flags.err && !q_side.flags.stop;
    end
  end

  `TPD_ASSERT_IMP(a_err_idle, out_valid && math_error, pulse_ns == IDLE_W[21:0])
  `TPD_ASSERT_IMP(a_one_bound, out_valid, !(clamped_low && clamped_high))
  `TPD_ASSERT_IMP(a_stall_only_full, in_stall, out_valid && out_stall)
  `TPD_ASSERT_NEXT(a_held_word, out_valid && out_stall, out_valid)

endmodule
